>>> src/bvpe_pkg.sv
// shared types and constants of the bitmap pixel expander
package bvpe_pkg;

  localparam int MEM_DEPTH = 8192;
  localparam int ADDR_W    = $clog2(MEM_DEPTH);
  localparam int BYTE_W    = 8;
  localparam int ROW_BYTES = 32;
  localparam int COL_W     = $clog2(ROW_BYTES);
  localparam int ROW_W     = ADDR_W - COL_W;
  localparam int PIX_W     = 3;
  localparam int COORD_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_SWAP_XY   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_X  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_MIRROR_Y  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLACK_PEN = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WHITE_PEN = 3'd4;

  localparam logic CMD_LOAD_MASK  = 1'b0;
  localparam logic CMD_WRITE_BYTE = 1'b1;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_COMPARE
  } state_t;

  typedef struct packed {
    logic              swap_xy;
    logic              mirror_x;
    logic              mirror_y;
    logic [BYTE_W-1:0] black_pen;
    logic [BYTE_W-1:0] white_pen;
  } cfg_t;

  typedef struct packed {
    logic              start;
    logic [BYTE_W-1:0] data;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
  } exp_cmd_t;

endpackage

>>> src/bvpe_if.sv
// request and pixel channel interfaces
interface bvpe_req_if;
  import bvpe_pkg::*;
  logic                valid;
  logic                ready;
  logic                command;
  logic [ADDR_W-1:0]   byte_address;
  logic [BYTE_W-1:0]   write_data;
  modport source (output valid, command, byte_address, write_data, input ready);
  modport sink   (input valid, command, byte_address, write_data, output ready);
endinterface

interface bvpe_pix_if;
  import bvpe_pkg::*;
  logic                valid;
  logic                ready;
  logic [COORD_W-1:0]  pixel_x;
  logic [COORD_W-1:0]  pixel_y;
  logic [BYTE_W-1:0]   pen;
  logic                last_pixel;
  modport source (output valid, pixel_x, pixel_y, pen, last_pixel, input ready);
  modport sink   (input valid, pixel_x, pixel_y, pen, last_pixel, output ready);
endinterface

>>> src/bvpe_ram.sv
// generic single write port ram with registered read
module bvpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> src/bvpe_expander.sv
// bit-serial byte to pixel expander with orientation and output register
module bvpe_expander
  import bvpe_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  exp_cmd_t   cmd,
  output logic       busy,
  bvpe_pix_if.source pix
);

  logic [PIX_W-1:0]   cnt;
  logic [BYTE_W-1:0]  shreg;
  logic [ROW_W-1:0]   row;
  logic [COL_W-1:0]   col;
  logic               ovalid;
  logic [COORD_W-1:0] ox;
  logic [COORD_W-1:0] oy;
  logic [BYTE_W-1:0]  open;
  logic               olast;

  logic               slot_free;
  logic [COORD_W-1:0] x_raw;
  logic [COORD_W-1:0] y_raw;
  logic [COORD_W-1:0] x_sw;
  logic [COORD_W-1:0] y_sw;

  assign slot_free = !ovalid || pix.ready;

  always_comb begin
    x_raw = {col, cnt};
    y_raw = row;
    x_sw  = cfg.swap_xy ? y_raw : x_raw;
    y_sw  = cfg.swap_xy ? x_raw : y_raw;
    if (cfg.mirror_x) begin
      x_sw = ~x_sw;
    end
    if (cfg.mirror_y) begin
      y_sw = ~y_sw;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy   <= 1'b0;
      ovalid <= 1'b0;
      cnt    <= '0;
    end else begin
      if (busy && slot_free) begin
        ovalid <= 1'b1;
        ox     <= x_sw;
        oy     <= y_sw;
        open   <= shreg[BYTE_W-1] ? cfg.white_pen : cfg.black_pen;
        olast  <= (cnt == '1);
        shreg  <= {shreg[BYTE_W-2:0], 1'b0};
        cnt    <= cnt + 1'b1;
        if (cnt == '1) begin
          busy <= 1'b0;
        end
      end else if (pix.ready) begin
        ovalid <= 1'b0;
      end
      if (cmd.start && !busy) begin
        busy  <= 1'b1;
        cnt   <= '0;
        shreg <= cmd.data;
        row   <= cmd.row;
        col   <= cmd.col;
      end
    end
  end

  assign pix.valid      = ovalid;
  assign pix.pixel_x    = ox;
  assign pix.pixel_y    = oy;
  assign pix.pen        = open;
  assign pix.last_pixel = olast;

endmodule

>>> src/bitmap_vram_pixel_expander_unit.sv
// top level of the bitmap video memory pixel expander
//
//  channel  dir  handshake          payload
//  req      in   valid/ready        command, byte_address, write_data
//  pix      out  valid/ready        pixel_x, pixel_y, pen, last_pixel
//  cfg      in   cfg_we             cfg_index, cfg_data
//
// after reset the 8192-entry memory is swept to zero, one byte a cycle
// a mask load is registered on acceptance; a byte write reads the ram, then compares
// a changed byte then streams 8 pixels, one per cycle unless pix stalls, through a shift register
// a new request is taken once the last pixel sits in the output register
// pix stalls hold the output register and pause the shift register
module bitmap_vram_pixel_expander_unit
  import bvpe_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  bvpe_req_if.sink             req,
  bvpe_pix_if.source           pix,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [BYTE_W-1:0]    cfg_data
);

  state_t            state;
  state_t            state_next;
  cfg_t              cfg;
  logic [BYTE_W-1:0] mask;
  logic [ADDR_W-1:0] addr_q;
  logic [BYTE_W-1:0] data_q;
  logic [ADDR_W-1:0] clr_cnt;

  logic              accept;
  logic              exp_busy;
  exp_cmd_t          exp_cmd;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_waddr;
  logic [BYTE_W-1:0] ram_wdata;
  logic [BYTE_W-1:0] ram_rdata;
  logic              changed;

  assign accept  = req.valid && req.ready;
  assign changed = (ram_rdata != data_q);

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_cnt == ADDR_W'(MEM_DEPTH - 1)) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept && req.command == CMD_WRITE_BYTE) begin
          state_next = ST_COMPARE;
        end
      end
      ST_COMPARE: state_next = ST_IDLE;
      default:    state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    req.ready     = 1'b0;
    ram_we        = 1'b0;
    ram_waddr     = addr_q;
    ram_wdata     = data_q;
    exp_cmd.start = 1'b0;
    exp_cmd.data  = data_q;
    exp_cmd.row   = addr_q[ADDR_W-1:COL_W];
    exp_cmd.col   = addr_q[COL_W-1:0];
    case (state)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = '0;
      end
      ST_IDLE: begin
        req.ready = !exp_busy;
      end
      ST_COMPARE: begin
        ram_we        = changed;
        exp_cmd.start = changed;
      end
      default: begin
        req.ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_CLEAR;
      clr_cnt <= '0;
      mask    <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_cnt <= clr_cnt + 1'b1;
      end
      if (accept && req.command == CMD_LOAD_MASK) begin
        mask <= req.write_data;
      end
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (accept) begin
      addr_q <= req.byte_address;
      data_q <= req.write_data & ~mask;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.swap_xy   <= 1'b0;
      cfg.mirror_x  <= 1'b0;
      cfg.mirror_y  <= 1'b0;
      cfg.black_pen <= '0;
      cfg.white_pen <= BYTE_W'(1);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SWAP_XY:   cfg.swap_xy   <= cfg_data[0];
        REG_MIRROR_X:  cfg.mirror_x  <= cfg_data[0];
        REG_MIRROR_Y:  cfg.mirror_y  <= cfg_data[0];
        REG_BLACK_PEN: cfg.black_pen <= cfg_data;
        REG_WHITE_PEN: cfg.white_pen <= cfg_data;
        default: ;
      endcase
    end
  end

  bvpe_ram #(
    .WIDTH(BYTE_W),
    .DEPTH(MEM_DEPTH)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .re   (accept),
    .raddr(req.byte_address),
    .rdata(ram_rdata)
  );

  bvpe_expander u_expander (
    .clk (clk),
    .rst (rst),
    .cfg (cfg),
    .cmd (exp_cmd),
    .busy(exp_busy),
    .pix (pix)
  );

endmodule

>>> dv/tb.sv
// testbench for the bitmap video memory pixel expander: shadow memory, directed and random requests, pixel checks
module tb;
  import bvpe_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 20;

  typedef struct packed {
    logic [COORD_W-1:0] x;
    logic [COORD_W-1:0] y;
    logic [BYTE_W-1:0]  pen;
    logic               last;
  } pixel_t;

  class vram_shadow;
    logic [BYTE_W-1:0] vram [MEM_DEPTH];
    logic [BYTE_W-1:0] mask;
    cfg_t              cfg;
    pixel_t            pending_pixels [$];
    int n_requests;
    int n_masks;
    int n_unchanged;
    int n_pixels;
    int n_errors;

    function new();
      foreach (vram[a]) vram[a] = '0;
      mask = '0;
      cfg  = '{swap_xy: 1'b0, mirror_x: 1'b0, mirror_y: 1'b0,
               black_pen: 8'd0, white_pen: 8'd1};
    endfunction

    function void apply_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
      case (idx)
        REG_SWAP_XY:   cfg.swap_xy   = value[0];
        REG_MIRROR_X:  cfg.mirror_x  = value[0];
        REG_MIRROR_Y:  cfg.mirror_y  = value[0];
        REG_BLACK_PEN: cfg.black_pen = value;
        REG_WHITE_PEN: cfg.white_pen = value;
        default: ;
      endcase
    endfunction

    function void take_request(logic cmd, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
      logic [BYTE_W-1:0]  kept;
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
      logic [COORD_W-1:0] t;
      pixel_t             p;
      n_requests++;
      if (cmd == CMD_LOAD_MASK) begin
        mask = data;
        n_masks++;
        return;
      end
      kept = data & ~mask;
      if (vram[addr] == kept) begin
        n_unchanged++;
        return;
      end
      vram[addr] = kept;
      for (int i = 0; i < BYTE_W; i++) begin
        x = {addr[COL_W-1:0], PIX_W'(i)};
        y = addr[ADDR_W-1:COL_W];
        if (cfg.swap_xy) begin
          t = x;
          x = y;
          y = t;
        end
        if (cfg.mirror_x) x = 8'd255 - x;
        if (cfg.mirror_y) y = 8'd255 - y;
        p.x    = x;
        p.y    = y;
        p.pen  = kept[BYTE_W-1-i] ? cfg.white_pen : cfg.black_pen;
        p.last = (i == BYTE_W - 1);
        pending_pixels.push_back(p);
      end
    endfunction

    function void flag(string what, int want, int got);
      n_errors++;
      if (n_errors <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, got %0d", $time, what, want, got);
    endfunction

    function void match_pixel(logic [COORD_W-1:0] x, logic [COORD_W-1:0] y,
                              logic [BYTE_W-1:0] pen, logic last);
      pixel_t want;
      if (pending_pixels.size() == 0) begin
        n_errors++;
        if (n_errors <= MAX_REPORTS)
          $display("%0t: pixel with no pending request, expected none, got x=%0d y=%0d pen=%0d",
                   $time, x, y, pen);
        return;
      end
      want = pending_pixels.pop_front();
      n_pixels++;
      if (x !== want.x) flag("pixel_x", want.x, x);
      if (y !== want.y) flag("pixel_y", want.y, y);
      if (pen !== want.pen) flag("pen", want.pen, pen);
      if (last !== want.last) flag("last_pixel", want.last, last);
    endfunction
  endclass

  logic clk;
  logic rst;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [BYTE_W-1:0]    cfg_data;

  bvpe_req_if req ();
  bvpe_pix_if pix ();

  bitmap_vram_pixel_expander_unit dut (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .pix       (pix),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  vram_shadow sb = new();

  int src_pct = 20;
  int sink_stall_pct = 20;
  int sink_hold = 0;
  int cycles = 0;
  int n_settings = 0;
  logic [ADDR_W-1:0] hot_addr [16];

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycles,
               sb.pending_pixels.size());
      $display("Verification failed");
      $finish;
    end
  end

  // pixel side: random stall bursts, check every accepted pixel
  always @(posedge clk) begin
    if (pix.valid === 1'b1 && pix.ready === 1'b1)
      sb.match_pixel(pix.pixel_x, pix.pixel_y, pix.pen, pix.last_pixel);
    if (sink_hold != 0) begin
      sink_hold <= sink_hold - 1;
      pix.ready <= 1'b0;
    end else if ($urandom_range(99) < sink_stall_pct) begin
      sink_hold <= $urandom_range(8, 0);
      pix.ready <= 1'b0;
    end else begin
      pix.ready <= 1'b1;
    end
  end

  task automatic send_request(logic cmd, logic [ADDR_W-1:0] addr, logic [BYTE_W-1:0] data);
    int gap;
    gap = ($urandom_range(99) < src_pct) ? $urandom_range(9, 1) : 0;
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req.valid        <= 1'b1;
    req.command      <= cmd;
    req.byte_address <= addr;
    req.write_data   <= data;
    @(posedge clk);
    while (req.ready !== 1'b1) @(posedge clk);
    sb.take_request(cmd, addr, data);
  endtask

  task automatic drain_and_settle();
    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [BYTE_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    sb.apply_register(idx, value);
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic random_request();
    int r;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(99);
    a = ($urandom_range(99) < 40) ? hot_addr[$urandom_range(15)] : ADDR_W'($urandom);
    if (r < 15)
      send_request(CMD_LOAD_MASK, a, ($urandom_range(1) == 0) ? 8'h00 : 8'($urandom));
    else if (r < 30)
      send_request(CMD_WRITE_BYTE, a, sb.vram[a] | (8'($urandom) & sb.mask));
    else
      send_request(CMD_WRITE_BYTE, a, 8'($urandom));
  endtask

  task automatic run_phase(cfg_t c, int items, int src_p, int sink_p);
    drain_and_settle();
    write_register(REG_SWAP_XY,   {7'($urandom), c.swap_xy});
    write_register(REG_MIRROR_X,  {7'($urandom), c.mirror_x});
    write_register(REG_MIRROR_Y,  {7'($urandom), c.mirror_y});
    write_register(REG_BLACK_PEN, c.black_pen);
    write_register(REG_WHITE_PEN, c.white_pen);
    for (int k = REG_WHITE_PEN + 1; k < (1 << CFG_IDX_W); k++)
      write_register(CFG_IDX_W'(k), 8'($urandom));
    src_pct        = src_p;
    sink_stall_pct = sink_p;
    n_settings++;
    for (int n = 0; n < items; n++) begin
      if (n == items / 2) drain_and_settle();
      random_request();
    end
  endtask

  initial begin
    rst              = 1'b1;
    cfg_we           = 1'b0;
    cfg_index        = '0;
    cfg_data         = '0;
    req.valid        = 1'b0;
    req.command      = CMD_LOAD_MASK;
    req.byte_address = '0;
    req.write_data   = '0;
    foreach (hot_addr[h]) hot_addr[h] = ADDR_W'($urandom);
    hot_addr[0]  = '0;
    hot_addr[15] = ADDR_W'(MEM_DEPTH - 1);
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed requests at reset settings
    send_request(CMD_WRITE_BYTE, 13'd0,    8'hFF);
    send_request(CMD_WRITE_BYTE, 13'd0,    8'hFF);
    send_request(CMD_WRITE_BYTE, 13'd8191, 8'h00);
    send_request(CMD_WRITE_BYTE, 13'd8191, 8'h80);
    send_request(CMD_WRITE_BYTE, 13'd31,   8'h01);
    send_request(CMD_WRITE_BYTE, 13'd8160, 8'hA5);
    send_request(CMD_WRITE_BYTE, 13'd8191, 8'h7F);
    send_request(CMD_LOAD_MASK,  13'd8191, 8'hFF);
    send_request(CMD_WRITE_BYTE, 13'd100,  8'h5A);
    send_request(CMD_LOAD_MASK,  13'd0,    8'h0F);
    send_request(CMD_WRITE_BYTE, 13'd100,  8'hFF);
    send_request(CMD_LOAD_MASK,  13'd4095, 8'hF0);
    send_request(CMD_WRITE_BYTE, 13'd100,  8'hFF);
    send_request(CMD_LOAD_MASK,  13'd0,    8'h00);
    send_request(CMD_WRITE_BYTE, 13'd0,    8'h00);
    send_request(CMD_WRITE_BYTE, 13'd4096, 8'h55);
    send_request(CMD_WRITE_BYTE, 13'd4096, 8'hAA);
    send_request(CMD_WRITE_BYTE, 13'd4096, 8'hAA);
    send_request(CMD_WRITE_BYTE, 13'd2730, 8'hC3);
    send_request(CMD_WRITE_BYTE, 13'd5461, 8'h3C);

    run_phase('{1'b0, 1'b0, 1'b0, 8'd0, 8'd1}, 80, 30, 30);
    run_phase('{1'b1, 1'b1, 1'b1, 8'd255, 8'd0}, 70, 10, 50);
    run_phase('{1'b1, 1'b0, 1'b0, 8'($urandom), 8'($urandom)}, 70, 0, 0);
    run_phase('{1'b0, 1'b1, 1'b0, 8'($urandom), 8'($urandom)}, 70, 50, 10);
    run_phase('{1'b0, 1'b0, 1'b1, 8'd0, 8'd255}, 70, 20, 20);
    // tail runs with no random request gaps or pixel stalls
    run_phase('{1'b1, 1'b1, 1'b0, 8'($urandom), 8'($urandom)}, 60, 0, 0);

    req.valid <= 1'b0;
    @(posedge clk);
    while (sb.pending_pixels.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    if (sb.pending_pixels.size() != 0) begin
      sb.n_errors++;
      $display("%0t: %0d pixels never arrived", $time, sb.pending_pixels.size());
    end

    $display("covered %0d requests: %0d mask loads, %0d unchanged writes, %0d pixels checked",
             sb.n_requests, sb.n_masks, sb.n_unchanged, sb.n_pixels);
    $display("over %0d register settings with swap, mirrors and pen extremes, %0d errors",
             n_settings, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
